### hw/rtl/ar7s_pkg.sv
package ar7s_pkg;

	localparam int VALUE_W = 27;
	localparam int SEG_W = 8;
	localparam int DRIVE_W = 6;
	localparam int DOT_W = 3;
	localparam int SLOT_W = 3;
	localparam int NUM_DIGITS = 4;
	localparam int BCD_DIGITS = 8;
	localparam int BCD_W = 4 * BCD_DIGITS;
	localparam int RANGE_W = 3;

	// double-dabble pipeline: steps per stage and stage count
	localparam int DD_STEPS = 7;
	localparam int DD_STAGES = (VALUE_W + DD_STEPS - 1) / DD_STEPS;

	localparam logic [VALUE_W-1:0] VALUE_MAX = 27'd99999999;
	localparam logic [VALUE_W-1:0] TH_1E7 = 27'd10000000;
	localparam logic [VALUE_W-1:0] TH_1E6 = 27'd1000000;
	localparam logic [VALUE_W-1:0] TH_1E5 = 27'd100000;
	localparam logic [VALUE_W-1:0] TH_1E4 = 27'd10000;

	// autorange codes: number of decimal digits dropped
	localparam logic [RANGE_W-1:0] RNG_RAW = 3'd0;
	localparam logic [RANGE_W-1:0] RNG_DIV10 = 3'd1;
	localparam logic [RANGE_W-1:0] RNG_DIV100 = 3'd2;
	localparam logic [RANGE_W-1:0] RNG_DIV1K = 3'd3;
	localparam logic [RANGE_W-1:0] RNG_DIV10K = 3'd4;

	localparam logic [DOT_W-1:0] DOT_NONE = 3'd4;
	localparam logic [DOT_W-1:0] DOT_1 = 3'd1;
	localparam logic [DOT_W-1:0] DOT_2 = 3'd2;
	localparam logic [DOT_W-1:0] DOT_3 = 3'd3;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [SLOT_W-1:0] SLOT_FIRST = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_IND = 3'd4;
	localparam logic [DRIVE_W-1:0] DRIVE_IDLE = 6'h3F;
	localparam int DRIVE_IND_BIT = 1;
	localparam int DRIVE_DIGIT_BASE = 2;

	typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic [VALUE_W-1:0] bin;
	} dd_t;

	// one entry of the front-to-back queue
	typedef struct packed {
		logic tick;
		digits_t digits;
		logic [DOT_W-1:0] dot;
		logic ind;
	} item_t;

	localparam int ITEM_W = $bits(item_t);

	// segment glyphs for decimal digits
	function automatic logic [SEG_W-1:0] glyph(input logic [3:0] d);
		logic [SEG_W-1:0] g;
		case (d)
			4'd0: g = 8'hFC;
			4'd1: g = 8'h84;
			4'd2: g = 8'hBA;
			4'd3: g = 8'hAE;
			4'd4: g = 8'hC6;
			4'd5: g = 8'h6E;
			4'd6: g = 8'h7E;
			4'd7: g = 8'hA4;
			4'd8: g = 8'hFE;
			4'd9: g = 8'hEE;
			default: g = 8'hFC;
		endcase
		return g;
	endfunction

	// one shift-add-3 step of binary to bcd conversion
	function automatic dd_t dd_step(input dd_t st);
		dd_t r;
		r = st;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (r.bcd[4*i +: 4] >= 4'd5) begin
				r.bcd[4*i +: 4] = r.bcd[4*i +: 4] + 4'd3;
			end
		end
		r = dd_t'({r.bcd, r.bin} << 1);
		return r;
	endfunction

endpackage

### hw/rtl/ar7s_front.sv
module ar7s_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic [ar7s_pkg::VALUE_W-1:0] value,
	input  logic                         q_full,
	output logic                         q_push,
	output ar7s_pkg::item_t              q_item
);
	import ar7s_pkg::*;

	typedef struct packed {
		logic tick;
		logic [RANGE_W-1:0] rng;
		logic [DOT_W-1:0] dot;
		logic ind;
	} side_t;

	logic [DD_STAGES:0] valid_s;
	dd_t state_s [DD_STAGES+1];
	side_t side_s [DD_STAGES+1];
	logic en;
	logic [VALUE_W-1:0] sat;
	side_t side_in;
	logic [BCD_W-1:0] shifted;

	// whole pipeline moves together, stalls only when the last stage holds an item and the queue is full
	assign en = !valid_s[DD_STAGES] || !q_full;
	assign in_ready = en;

	// saturate and classify
	always_comb begin
		sat = (value > VALUE_MAX) ? VALUE_MAX : value;
		side_in.tick = (cmd == CMD_TICK);
		if (sat >= TH_1E7) begin
			side_in.rng = RNG_DIV10K;
			side_in.dot = DOT_NONE;
			side_in.ind = 1'b1;
		end else if (sat >= TH_1E6) begin
			side_in.rng = RNG_DIV1K;
			side_in.dot = DOT_1;
			side_in.ind = 1'b1;
		end else if (sat >= TH_1E5) begin
			side_in.rng = RNG_DIV100;
			side_in.dot = DOT_2;
			side_in.ind = 1'b1;
		end else if (sat >= TH_1E4) begin
			side_in.rng = RNG_DIV10;
			side_in.dot = DOT_3;
			side_in.ind = 1'b1;
		end else begin
			side_in.rng = RNG_RAW;
			side_in.dot = DOT_1;
			side_in.ind = 1'b0;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[DD_STAGES-1:0], in_valid};
		end
	end

	// entry stage
	always_ff @(posedge clk) begin
		if (en) begin
			state_s[0] <= '{bcd: '0, bin: sat};
			side_s[0] <= side_in;
		end
	end

	// conversion stages, a few double-dabble steps each
	for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
		dd_t nxt;
		always_comb begin
			nxt = state_s[g];
			for (int k = 0; k < DD_STEPS; k++) begin
				if (g * DD_STEPS + k < VALUE_W) begin
					nxt = dd_step(nxt);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				state_s[g+1] <= nxt;
				side_s[g+1] <= side_s[g];
			end
		end
	end

	// pick the four shown digits by range
	always_comb begin
		shifted = state_s[DD_STAGES].bcd >> {side_s[DD_STAGES].rng, 2'b00};
		q_item.tick = side_s[DD_STAGES].tick;
		q_item.digits = shifted[4*NUM_DIGITS-1:0];
		q_item.dot = side_s[DD_STAGES].dot;
		q_item.ind = side_s[DD_STAGES].ind;
	end

	assign q_push = valid_s[DD_STAGES] && !q_full;

endmodule

### hw/rtl/ar7s_queue.sv
module ar7s_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ar7s_pkg::item_t push_item,
	input  logic            pop,
	output ar7s_pkg::item_t head,
	output logic            empty,
	output logic            full
);
	import ar7s_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == FULL_CNT);
	assign head = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue pop while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("queue count out of range");

endmodule

### hw/rtl/ar7s_back.sv
module ar7s_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  ar7s_pkg::item_t              q_head,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ar7s_pkg::SEG_W-1:0]   segments,
	output logic [ar7s_pkg::DRIVE_W-1:0] drive_lines,
	output logic                         dot_on,
	output logic [ar7s_pkg::SLOT_W-1:0]  scan_slot
);
	import ar7s_pkg::*;

	logic [SEG_W-1:0] pat_q [NUM_DIGITS];
	logic [DOT_W-1:0] dot_pos_q;
	logic ind_q;
	logic [SLOT_W-1:0] scan_q;
	logic [SEG_W-1:0] latch_q;
	logic out_valid_q;
	logic [SEG_W-1:0] seg_q;
	logic [DRIVE_W-1:0] drive_q;
	logic dot_q;
	logic [SLOT_W-1:0] slot_q;

	logic take_tick;
	logic take_update;
	logic [SLOT_W-1:0] slot;
	logic [SLOT_W-1:0] slot_next;
	logic [SEG_W-1:0] latch_next;
	logic [DRIVE_W-1:0] drive;
	logic dot;

	// updates never wait, ticks wait for the output register
	assign q_pop = !q_empty && (!q_head.tick || !out_valid_q || out_ready);
	assign take_tick = q_pop && q_head.tick;
	assign take_update = q_pop && !q_head.tick;

	// slot decode
	always_comb begin
		slot = (scan_q > SLOT_IND) ? SLOT_FIRST : scan_q;
		slot_next = (slot == SLOT_IND) ? SLOT_FIRST : slot + 1'b1;
		drive = DRIVE_IDLE;
		dot = 1'b0;
		latch_next = latch_q;
		if (slot != SLOT_IND) begin
			dot = (dot_pos_q == slot);
			latch_next = pat_q[slot[1:0]];
			drive[{1'b0, slot[1:0]} + 3'(DRIVE_DIGIT_BASE)] = 1'b0;
		end else if (ind_q) begin
			drive[DRIVE_IND_BIT] = 1'b0;
		end
	end

	// display state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q[0] <= glyph(4'd0);
			pat_q[1] <= glyph(4'd1);
			pat_q[2] <= glyph(4'd2);
			pat_q[3] <= glyph(4'd3);
			dot_pos_q <= '0;
			ind_q <= 1'b0;
			scan_q <= SLOT_FIRST;
			latch_q <= '0;
		end else if (take_update) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				pat_q[i] <= glyph(q_head.digits[i]);
			end
			dot_pos_q <= q_head.dot;
			ind_q <= q_head.ind;
		end else if (take_tick) begin
			scan_q <= slot_next;
			latch_q <= latch_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_tick) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_tick) begin
			seg_q <= latch_next;
			drive_q <= drive;
			dot_q <= dot;
			slot_q <= slot;
		end
	end

	assign out_valid = out_valid_q;
	assign segments = seg_q;
	assign drive_lines = drive_q;
	assign dot_on = dot_q;
	assign scan_slot = slot_q;

	a_scan_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= SLOT_IND)
		else $error("scan position out of range");

	a_tick_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		take_tick |=> out_valid_q)
		else $error("tick transfer lost its result");

	a_ind_slot_no_dot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && slot_q == SLOT_IND |-> !dot_q && drive_q[DRIVE_W-1:DRIVE_DIGIT_BASE] == '1)
		else $error("indicator slot drives a digit");

endmodule

### hw/rtl/autorange_seven_segment_scanner_core.sv
// path: a tick result passes the entry register (loaded at the transfer), then 4
//   conversion stages, one queue write and one output register; updates take effect
//   in the same order
// throughput: one item per cycle, updates and ticks alike; the front pipeline stalls
//   only when the queue is full, the back only when a result waits on out_ready
// reset: arst_n clears all control state, digits reset to 0,1,2,3 glyphs,
//   dot, indicator, scan position and segment latch to zero
module autorange_seven_segment_scanner_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic [ar7s_pkg::VALUE_W-1:0] value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ar7s_pkg::SEG_W-1:0]   segments,
	output logic [ar7s_pkg::DRIVE_W-1:0] drive_lines,
	output logic                         dot_on,
	output logic [ar7s_pkg::SLOT_W-1:0]  scan_slot
);
	import ar7s_pkg::*;

	item_t push_item, head;
	logic push, pop, empty, full;

	// classify and convert to bcd
	ar7s_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.value    (value),
		.q_full   (full),
		.q_push   (push),
		.q_item   (push_item)
	);

	// decoupling queue
	ar7s_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	// display state and scan
	ar7s_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (empty),
		.q_head      (head),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.segments    (segments),
		.drive_lines (drive_lines),
		.dot_on      (dot_on),
		.scan_slot   (scan_slot)
	);

endmodule

### tb/sv/autorange_seven_segment_scanner_core_tb.sv
module autorange_seven_segment_scanner_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ar7s_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 600;
	localparam int STEADY_FROM = 250;
	localparam int STEADY_TO = 450;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [SEG_W-1:0] DIGIT_GLYPH [10] = '{
		8'hFC, 8'h84, 8'hBA, 8'hAE, 8'hC6, 8'h6E, 8'h7E, 8'hA4, 8'hFE, 8'hEE
	};

	// one input item and one scan result
	typedef struct {
		logic cmd;
		logic [VALUE_W-1:0] value;
	} scan_req_t;

	typedef struct {
		logic [SEG_W-1:0] segs;
		logic [DRIVE_W-1:0] drive;
		logic dot;
		logic [SLOT_W-1:0] slot;
	} scan_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = CMD_UPDATE;
	logic [VALUE_W-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [SEG_W-1:0] segments;
	logic [DRIVE_W-1:0] drive_lines;
	logic dot_on;
	logic [SLOT_W-1:0] scan_slot;

	scan_req_t pending_reqs[$];
	scan_out_t expected_scans[$];

	// display state as the block should hold it
	logic [SEG_W-1:0] shown_glyph [NUM_DIGITS];
	logic [DOT_W-1:0] shown_dot;
	logic shown_ind;
	logic [SLOT_W-1:0] next_slot;
	logic [SEG_W-1:0] seg_hold;

	int cycle = 0;
	int errors = 0;
	int total_items = 0;
	int accepted = 0;
	int n_updates = 0;
	int n_ticks = 0;
	int n_checked = 0;
	bit steady;

	autorange_seven_segment_scanner_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.segments(segments),
		.drive_lines(drive_lines),
		.dot_on(dot_on),
		.scan_slot(scan_slot)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("cycle %0d: %s mismatch, got 0x%0h, want 0x%0h", cycle, what, got, want);
		errors++;
	endtask

	// autorange a measurement or advance the scan by one slot
	task automatic predict_transfer(input logic c, input logic [VALUE_W-1:0] raw);
		int unsigned v;
		scan_out_t s;
		if (c == CMD_UPDATE) begin
			v = raw;
			if (v > VALUE_MAX) v = VALUE_MAX;
			shown_ind = (v >= TH_1E4);
			if (v >= TH_1E7) begin
				v = v / 10000;
				shown_dot = DOT_NONE;
			end else if (v >= TH_1E6) begin
				v = v / 1000;
				shown_dot = DOT_1;
			end else if (v >= TH_1E5) begin
				v = v / 100;
				shown_dot = DOT_2;
			end else if (v >= TH_1E4) begin
				v = v / 10;
				shown_dot = DOT_3;
			end else begin
				shown_dot = DOT_1;
			end
			for (int k = 0; k < NUM_DIGITS; k++) begin
				shown_glyph[k] = DIGIT_GLYPH[v % 10];
				v = v / 10;
			end
			n_updates++;
		end else begin
			s.slot = next_slot;
			s.drive = DRIVE_IDLE;
			s.dot = 1'b0;
			if (next_slot != SLOT_IND) begin
				s.dot = (shown_dot == next_slot);
				seg_hold = shown_glyph[next_slot[1:0]];
				s.drive[DRIVE_DIGIT_BASE + next_slot] = 1'b0;
			end else if (shown_ind) begin
				s.drive[DRIVE_IND_BIT] = 1'b0;
			end
			s.segs = seg_hold;
			next_slot = (next_slot == SLOT_IND) ? SLOT_FIRST : next_slot + 1'b1;
			expected_scans.push_back(s);
			n_ticks++;
		end
	endtask

	function automatic void queue_item(input logic c, input logic [VALUE_W-1:0] v);
		scan_req_t r;
		r.cmd = c;
		r.value = v;
		pending_reqs.push_back(r);
	endfunction

	// long stretch with no idling on either side
	assign steady = (accepted >= STEADY_FROM) && (accepted < STEADY_TO);

	// input driver: present the next item once the current one has transferred
	always @(posedge clk) begin : drive_items
		bit holding;
		scan_req_t r;
		if (arst_n) begin
			holding = in_valid;
			if (in_valid && in_ready) begin
				predict_transfer(cmd, value);
				accepted++;
				holding = 1'b0;
			end
			if (!holding) begin
				if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 19)) begin
					r = pending_reqs.pop_front();
					in_valid <= 1'b1;
					cmd <= r.cmd;
					value <= r.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor: compare each transfer with the oldest expectation
	always @(posedge clk) begin : check_results
		scan_out_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_scans.size() == 0) begin
					report_mismatch("unexpected result slot", scan_slot, 0);
				end else begin
					e = expected_scans.pop_front();
					if (segments !== e.segs) report_mismatch("segments", segments, e.segs);
					if (drive_lines !== e.drive)
						report_mismatch("drive_lines", drive_lines, e.drive);
					if (dot_on !== e.dot) report_mismatch("dot_on", dot_on, e.dot);
					if (scan_slot !== e.slot) report_mismatch("scan_slot", scan_slot, e.slot);
					n_checked++;
				end
			end
			out_ready <= steady || ($urandom_range(99) >= 19);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle,
				expected_scans.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int n;
		logic [VALUE_W-1:0] v;

		// state after reset
		shown_glyph = '{8'hFC, 8'h84, 8'hBA, 8'hAE};
		shown_dot = '0;
		shown_ind = 1'b0;
		next_slot = SLOT_FIRST;
		seg_hold = '0;

		// full scan of the reset display, dot on slot 0
		repeat (5) queue_item(CMD_TICK, '0);
		// raw zero, then a full scan
		queue_item(CMD_UPDATE, 27'd0);
		repeat (5) queue_item(CMD_TICK, '1);
		// range edges, all-ones and saturation, one tick after each
		queue_item(CMD_UPDATE, 27'd9999);
		queue_item(CMD_TICK, '0);
		queue_item(CMD_UPDATE, 27'd10000);
		queue_item(CMD_TICK, '0);
		queue_item(CMD_UPDATE, 27'd100000);
		queue_item(CMD_TICK, '0);
		queue_item(CMD_UPDATE, 27'd1000000);
		queue_item(CMD_TICK, '0);
		queue_item(CMD_UPDATE, 27'd10000000);
		queue_item(CMD_TICK, '0);
		queue_item(CMD_UPDATE, '1);
		queue_item(CMD_TICK, '0);
		queue_item(CMD_UPDATE, 27'd99999999);
		queue_item(CMD_TICK, '0);

		// random measurements, mostly followed by runs of ticks
		n = 0;
		while (n < RANDOM_ITEMS) begin
			if ($urandom_range(99) < 80) begin
				case ($urandom_range(7))
					0: v = VALUE_W'($urandom_range(9999));
					1: v = VALUE_W'($urandom_range(99999, 10000));
					2: v = VALUE_W'($urandom_range(999999, 100000));
					3: v = VALUE_W'($urandom_range(9999999, 1000000));
					4: v = VALUE_W'($urandom_range(99999999, 10000000));
					5: v = VALUE_W'($urandom_range((1 << VALUE_W) - 1, 100000000));
					default: v = VALUE_W'($urandom());
				endcase
				queue_item(CMD_UPDATE, v);
				n++;
			end
			repeat ($urandom_range(7)) begin
				queue_item(CMD_TICK, VALUE_W'($urandom()));
				n++;
			end
		end
		total_items = pending_reqs.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted < total_items || expected_scans.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items sent: %0d measurement updates across all ranges, %0d scan ticks",
			total_items, n_updates, n_ticks);
		$display("%0d scan results compared, %0d mismatches", n_checked, errors);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/ar7s_pkg.sv
hw/rtl/ar7s_front.sv
hw/rtl/ar7s_queue.sv
hw/rtl/ar7s_back.sv
hw/rtl/autorange_seven_segment_scanner_core.sv
tb/sv/autorange_seven_segment_scanner_core_tb.sv
